// ----- hdl/rgbyuv_pkg.sv -----
// Package for the RGB32 to YUV 4:2:0 converter.
// Holds the sizes, register indexes, plane codes and the structs shared between the modules.
// No dependencies.
`default_nettype none
package rgbyuv_pkg;

    // Frame limits and widths derived from them
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int LINE_DEPTH  = MAX_WIDTH / 2;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int PAIR_W      = $clog2(LINE_DEPTH);
    localparam int SIZE_W      = 13;
    localparam int TOTAL_W     = 25;
    localparam int ADDR_W      = 24;
    localparam int CIDX_W      = 22;
    localparam int PIX_W       = 8;
    localparam int SUM_W       = 18;
    localparam int PART_W      = 2 * SUM_W;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

    // Plane codes of a result word
    localparam int PLANE_W = 2;
    localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

    // Position of the pixel being accepted
    typedef struct packed {
        logic              col_odd;
        logic              row_odd;
        logic [PAIR_W-1:0] pair;
        logic [ADDR_W-1:0] lidx;
        logic [CIDX_W-1:0] cidx;
    } t_pos;

    // Finished samples and addresses of one pixel
    typedef struct packed {
        logic              chroma;
        logic [PIX_W-1:0]  y;
        logic [PIX_W-1:0]  u;
        logic [PIX_W-1:0]  v;
        logic [ADDR_W-1:0] laddr;
        logic [ADDR_W-1:0] caddr;
    } t_res;

    // Effective frame size: low bit cleared and clamped to 2..limit
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] val,
                                                    input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] v;
        v = {val[SIZE_W-1:1], 1'b0};
        if (v < SIZE_W'(2)) begin
            v = SIZE_W'(2);
        end
        if (v > lim) begin
            v = lim;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/rgbyuv_pos.sv -----
// Configuration registers, frame size product and raster position counters.
// Depends on rgbyuv_pkg.
`default_nettype none
module rgbyuv_pos (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [rgbyuv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [rgbyuv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                               i_pix_accept,
    output rgbyuv_pkg::t_pos                  o_pos,
    output logic [rgbyuv_pkg::TOTAL_W-1:0]    o_total,
    output logic                              o_restart
);
    import rgbyuv_pkg::*;

    logic [SIZE_W-1:0]  r_frame_width;
    logic [SIZE_W-1:0]  r_frame_height;
    logic [TOTAL_W-1:0] r_total;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [ADDR_W-1:0]  r_lidx, n_lidx;
    logic [CIDX_W-1:0]  r_cidx, n_cidx;
    logic [SIZE_W-1:0]  w_eff, h_eff;
    logic [2*SIZE_W-1:0] product;
    logic               cfg_wr;
    logic               line_end, frame_end;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid && ((i_cfg_index == CFG_FRAME_WIDTH) ||
                                    (i_cfg_index == CFG_FRAME_HEIGHT));
    assign o_restart = cfg_wr;

    // Configuration registers; a write of either size register returns to the frame start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_valid && i_cfg_index == CFG_FRAME_WIDTH) begin
            r_frame_width <= i_cfg_data;
        end else if (i_cfg_valid && i_cfg_index == CFG_FRAME_HEIGHT) begin
            r_frame_height <= i_cfg_data;
        end
    end

    // Effective sizes and the plane size, registered after the multiplier.
    assign w_eff   = eff_size(r_frame_width, SIZE_W'(MAX_WIDTH));
    assign h_eff   = eff_size(r_frame_height, SIZE_W'(MAX_HEIGHT));
    assign product = w_eff * h_eff;

    always_ff @(posedge i_clk) begin
        r_total <= product[TOTAL_W-1:0];
    end
    assign o_total = r_total;

    // Raster position of the next pixel.
    assign line_end  = (({1'b0, r_col} + SIZE_W'(1)) == w_eff);
    assign frame_end = line_end && (({1'b0, r_row} + SIZE_W'(1)) == h_eff);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_lidx = r_lidx;
        n_cidx = r_cidx;
        if (cfg_wr) begin
            n_col  = '0;
            n_row  = '0;
            n_lidx = '0;
            n_cidx = '0;
        end else if (i_pix_accept) begin
            n_col  = r_col + COL_W'(1);
            n_lidx = r_lidx + ADDR_W'(1);
            if (r_col[0] && r_row[0]) begin
                n_cidx = r_cidx + CIDX_W'(1);
            end
            if (line_end) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end
            if (frame_end) begin
                n_row  = '0;
                n_lidx = '0;
                n_cidx = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_lidx <= '0;
            r_cidx <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_lidx <= n_lidx;
            r_cidx <= n_cidx;
        end
    end

    assign o_pos.col_odd = r_col[0];
    assign o_pos.row_odd = r_row[0];
    assign o_pos.pair    = r_col[COL_W-1:1];
    assign o_pos.lidx    = r_lidx;
    assign o_pos.cidx    = r_cidx;

endmodule
`default_nettype wire

// ----- hdl/rgbyuv_calc.sv -----
// Input register, colour arithmetic, 2x2 chroma accumulation and the line store.
// Depends on rgbyuv_pkg.
`default_nettype none
module rgbyuv_calc (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [rgbyuv_pkg::PIX_W-1:0]    i_blue,
    input  wire  [rgbyuv_pkg::PIX_W-1:0]    i_green,
    input  wire  [rgbyuv_pkg::PIX_W-1:0]    i_red,
    input  rgbyuv_pkg::t_pos                i_pos,
    input  wire  [rgbyuv_pkg::TOTAL_W-1:0]  i_total,
    input  wire                             i_restart,
    output logic                            o_accept,
    output logic                            o_res_valid,
    input  wire                             i_res_ready,
    output rgbyuv_pkg::t_res                o_res
);
    import rgbyuv_pkg::*;

    localparam logic signed [SUM_W-1:0] K_UR = 18'sd43;
    localparam logic signed [SUM_W-1:0] K_UG = 18'sd84;
    localparam logic signed [SUM_W-1:0] K_UB = 18'sd127;
    localparam logic signed [SUM_W-1:0] K_VR = 18'sd127;
    localparam logic signed [SUM_W-1:0] K_VG = 18'sd106;
    localparam logic signed [SUM_W-1:0] K_VB = 18'sd21;
    localparam logic signed [SUM_W-1:0] K_RND = 18'sd512;

    logic [PART_W-1:0] mem_line [LINE_DEPTH];

    logic                    r_valid;
    logic [PIX_W-1:0]        r_blue, r_green, r_red;
    t_pos                    r_pos;
    logic [PART_W-1:0]       r_line;
    logic signed [SUM_W-1:0] r_pp_u, r_pp_v;
    logic                    advance;
    logic [16:0]             y_sum;
    logic signed [SUM_W-1:0] bx, gx, rx;
    logic signed [SUM_W-1:0] u_px, v_px, su, sv, tu, tv, ru, rv;
    logic [TOTAL_W-1:0]      laddr_full, caddr_full;

    assign advance    = r_valid && i_res_ready;
    assign o_in_ready = !r_valid || i_res_ready;
    assign o_accept   = i_in_valid && o_in_ready;

    // Input register with its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_blue  <= i_blue;
            r_green <= i_green;
            r_red   <= i_red;
            r_pos   <= i_pos;
        end
    end

    // Line store of pair sums; read as the pixel enters, written as it leaves.
    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_line <= mem_line[i_pos.pair];
        end
        if (advance && r_pos.col_odd && !r_pos.row_odd) begin
            mem_line[r_pos.pair] <= {su, sv};
        end
    end

    // Partial sums of the even pixel of the current pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_pp_u <= '0;
            r_pp_v <= '0;
        end else if (advance && !r_pos.col_odd) begin
            r_pp_u <= u_px;
            r_pp_v <= v_px;
        end
    end

    // Luma and per-pixel chroma terms.
    assign y_sum = 17'(17'd76 * r_red) + 17'(17'd150 * r_green) + 17'(17'd29 * r_blue)
                 + 17'd128;
    assign bx    = signed'({10'd0, r_blue});
    assign gx    = signed'({10'd0, r_green});
    assign rx    = signed'({10'd0, r_red});
    assign u_px  = K_UB * bx - K_UR * rx - K_UG * gx;
    assign v_px  = K_VR * rx - K_VG * gx - K_VB * bx;

    // Pair and block sums, then rounding and the offset of 128.
    assign su = r_pp_u + u_px;
    assign sv = r_pp_v + v_px;
    assign tu = su + signed'(r_line[PART_W-1:SUM_W]);
    assign tv = sv + signed'(r_line[SUM_W-1:0]);
    assign ru = tu + K_RND;
    assign rv = tv + K_RND;

    // Addresses counted back from the end of each plane.
    assign laddr_full = i_total - TOTAL_W'(1) - TOTAL_W'(r_pos.lidx);
    assign caddr_full = (i_total >> 2) - TOTAL_W'(1) - TOTAL_W'(r_pos.cidx);

    assign o_res_valid  = r_valid;
    assign o_res.chroma = r_pos.col_odd && r_pos.row_odd;
    assign o_res.y      = y_sum[15:8];
    assign o_res.u      = ru[SUM_W-1:10] + PIX_W'(128);
    assign o_res.v      = rv[SUM_W-1:10] + PIX_W'(128);
    assign o_res.laddr  = laddr_full[ADDR_W-1:0];
    assign o_res.caddr  = caddr_full[ADDR_W-1:0];

endmodule
`default_nettype wire

// ----- hdl/rgbyuv_out.sv -----
// Result register that sends the luma word and, at a block's end, the U and V words.
// Depends on rgbyuv_pkg.
`default_nettype none
module rgbyuv_out (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_res_valid,
    output logic                             o_res_ready,
    input  rgbyuv_pkg::t_res                 i_res,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [rgbyuv_pkg::PLANE_W-1:0]   o_plane,
    output logic [rgbyuv_pkg::ADDR_W-1:0]    o_address,
    output logic [rgbyuv_pkg::PIX_W-1:0]     o_sample,
    output logic                             o_last
);
    import rgbyuv_pkg::*;

    logic                 r_valid;
    t_res                 r_res;
    logic [PLANE_W-1:0]   r_step;
    logic                 is_last;
    logic                 out_take;

    assign is_last     = !r_res.chroma || (r_step == PLANE_V);
    assign out_take    = r_valid && i_out_ready;
    assign o_res_ready = !r_valid || (i_out_ready && is_last);

    // Word sequencing: luma first, then U and V where the pixel closes a block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= PLANE_Y;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
            r_step  <= PLANE_Y;
        end else if (out_take) begin
            case (r_step)
                PLANE_Y: r_step <= PLANE_U;
                PLANE_U: r_step <= PLANE_V;
                default: r_step <= PLANE_Y;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    always_comb begin
        case (r_step)
            PLANE_U: o_sample = r_res.u;
            PLANE_V: o_sample = r_res.v;
            default: o_sample = r_res.y;
        endcase
    end

    assign o_out_valid = r_valid;
    assign o_plane     = r_step;
    assign o_address   = (r_step == PLANE_Y) ? r_res.laddr : r_res.caddr;
    assign o_last      = is_last;

endmodule
`default_nettype wire

// ----- hdl/rgb32_to_yuv420_converter_top.sv -----
// Top level of the RGB32 to YUV 4:2:0 converter with 180 degree rotated addressing.
// Depends on rgbyuv_pkg, rgbyuv_pos, rgbyuv_calc and rgbyuv_out.
//
// Pixels enter in raster order, one word per handshake, and every pixel gives a
// luma word; the odd pixel of an odd line also gives the U and V words of its
// 2x2 block, after the luma word. Addresses count back from the end of each
// plane. Results go out one word per cycle while the output is ready, from
// a single result register, which a pixel that closes a block holds for its
// luma, U and V words. An accepted pixel passes through the input register and
// then the result register on its way out. A new pixel is taken while the last
// word of the previous one is being delivered. Pair sums of even lines are held
// in a 2048 entry line store; it needs no clearing after reset. A write of
// frame_width or frame_height restarts the frame and must be made while idle.
`default_nettype none
module rgb32_to_yuv420_converter_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [rgbyuv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [rgbyuv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  [rgbyuv_pkg::PIX_W-1:0]      i_blue,
    input  wire  [rgbyuv_pkg::PIX_W-1:0]      i_green,
    input  wire  [rgbyuv_pkg::PIX_W-1:0]      i_red,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [rgbyuv_pkg::PLANE_W-1:0]    o_plane,
    output logic [rgbyuv_pkg::ADDR_W-1:0]     o_address,
    output logic [rgbyuv_pkg::PIX_W-1:0]      o_sample,
    output logic                              o_last
);
    import rgbyuv_pkg::*;

    t_pos               pos;
    t_res               res;
    logic [TOTAL_W-1:0] total;
    logic               restart;
    logic               pix_accept;
    logic               res_valid;
    logic               res_ready;

    // Configuration and position tracking.
    rgbyuv_pos u_pos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pix_accept (pix_accept),
        .o_pos        (pos),
        .o_total      (total),
        .o_restart    (restart)
    );

    // Colour conversion and chroma accumulation.
    rgbyuv_calc u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .i_pos       (pos),
        .i_total     (total),
        .i_restart   (restart),
        .o_accept    (pix_accept),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Result sequencing.
    rgbyuv_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_plane     (o_plane),
        .o_address   (o_address),
        .o_sample    (o_sample),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

// ----- sim/rgb32_to_yuv420_converter_top_tb.sv -----
// Self-checking testbench for the RGB32 to YUV 4:2:0 converter top level.
// Depends on rgbyuv_pkg and rgb32_to_yuv420_converter_top; a built-in predictor
// works out every luma and chroma word, which is checked as it leaves the block.
`default_nettype none
module rgb32_to_yuv420_converter_top_tb;
    import rgbyuv_pkg::*;

    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int DRAIN_LIMIT    = 20_000;
    localparam int RANDOM_PIXELS  = 240;
    // Indexes beyond the register list; the block ignores writes to them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // One result word as it leaves the block.
    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic [ADDR_W-1:0]  address;
        logic [PIX_W-1:0]   sample;
        logic               last;
    } t_yuv_word;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [PIX_W-1:0]      i_blue      = '0;
    logic [PIX_W-1:0]      i_green     = '0;
    logic [PIX_W-1:0]      i_red       = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [PLANE_W-1:0]    o_plane;
    logic [ADDR_W-1:0]     o_address;
    logic [PIX_W-1:0]      o_sample;
    logic                  o_last;

    // Words predicted but not yet delivered, oldest first.
    t_yuv_word yuv_words_due[$];
    int        fail_count = 0;

    // Idling controls shared by the stimulus and the output side.
    bit src_gaps      = 1'b0;
    bit sink_stalls   = 1'b0;
    int sink_hold_req = 0;

    // Predictor copy of the registers and the position within the frame.
    logic [SIZE_W-1:0] width_reg  = WIDTH_RESET;
    logic [SIZE_W-1:0] height_reg = HEIGHT_RESET;
    int unsigned       col_pos    = 0;
    int unsigned       row_pos    = 0;
    int                pend_u     = 0;
    int                pend_v     = 0;
    int                line_u[LINE_DEPTH];
    int                line_v[LINE_DEPTH];

    rgb32_to_yuv420_converter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_plane     (o_plane),
        .o_address   (o_address),
        .o_sample    (o_sample),
        .o_last      (o_last)
    );

    // Clock with a period of 12 units.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Every mismatch is printed on one line and counted.
    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what,
                 want, got);
        fail_count++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Channel levels lean towards the two extremes.
    function automatic logic [PIX_W-1:0] random_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Usable frame size: low bit cleared, then clamped to 2..limit.
    function automatic int unsigned frame_extent(input logic [SIZE_W-1:0] raw,
                                                 input int unsigned limit);
        int unsigned v;
        v = {raw[SIZE_W-1:1], 1'b0};
        if (v < 2) begin
            v = 2;
        end
        if (v > limit) begin
            v = limit;
        end
        return v;
    endfunction

    // Chroma sum to sample: rounded, floored divide by 1024, then offset by 128.
    function automatic logic [PIX_W-1:0] chroma_sample(input int sum);
        int t;
        t = ((sum + 512) >>> 10) + 128;
        return t[PIX_W-1:0];
    endfunction

    function automatic t_yuv_word yuv_word(input logic [PLANE_W-1:0] plane,
                                           input int unsigned addr,
                                           input logic [PIX_W-1:0] sample,
                                           input logic last);
        t_yuv_word w;
        w.plane   = plane;
        w.address = addr[ADDR_W-1:0];
        w.sample  = sample;
        w.last    = last;
        return w;
    endfunction

    // Works out the words of one accepted pixel and moves the position on.
    function automatic void predict_yuv_words(input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] r);
        int unsigned w, h, total, pair, luma_addr, chroma_addr;
        int          bi, gi, ri, luma, cu, cv, su, sv;
        w = frame_extent(width_reg, MAX_WIDTH);
        h = frame_extent(height_reg, MAX_HEIGHT);
        if (col_pos >= w) begin
            col_pos = 0;
        end
        if (row_pos >= h) begin
            row_pos = 0;
        end
        bi        = int'(b);
        gi        = int'(g);
        ri        = int'(r);
        pair      = (col_pos >> 1) % LINE_DEPTH;
        total     = w * h;
        luma_addr = total - 1 - (row_pos * w + col_pos);
        luma      = (76 * ri + 150 * gi + 29 * bi + 128) >>> 8;
        cu        = -43 * ri - 84 * gi + 127 * bi;
        cv        = 127 * ri - 106 * gi - 21 * bi;

        if (col_pos[0] == 1'b0) begin
            // First pixel of a pair: hold its chroma until the second arrives.
            pend_u = cu;
            pend_v = cv;
            yuv_words_due.push_back(yuv_word(PLANE_Y, luma_addr, luma[PIX_W-1:0], 1'b1));
        end else if (row_pos[0] == 1'b0) begin
            // Even line: the pair sum waits in the line store for the next line.
            line_u[pair] = pend_u + cu;
            line_v[pair] = pend_v + cv;
            yuv_words_due.push_back(yuv_word(PLANE_Y, luma_addr, luma[PIX_W-1:0], 1'b1));
        end else begin
            // Odd line: the 2x2 block is complete, so U and V follow the luma word.
            su          = pend_u + cu + line_u[pair];
            sv          = pend_v + cv + line_v[pair];
            chroma_addr = total / 4 - 1 - ((row_pos >> 1) * (w >> 1) + (col_pos >> 1));
            yuv_words_due.push_back(yuv_word(PLANE_Y, luma_addr, luma[PIX_W-1:0], 1'b0));
            yuv_words_due.push_back(yuv_word(PLANE_U, chroma_addr, chroma_sample(su), 1'b0));
            yuv_words_due.push_back(yuv_word(PLANE_V, chroma_addr, chroma_sample(sv), 1'b1));
        end

        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) begin
                row_pos = 0;
            end
        end
    endfunction

    // Offers one pixel, keeping valid high across back-to-back words.
    task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] r);
        int gap;
        gap = 0;
        if (src_gaps && $urandom_range(0, 2) == 0) begin
            gap = idle_length();
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_blue     <= b;
        i_green    <= g;
        i_red      <= r;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predict_yuv_words(b, g, r);
    endtask

    task automatic send_random_pixels(input int count);
        repeat (count) begin
            send_pixel(random_level(), random_level(), random_level());
        end
    endtask

    // Stops offering pixels and waits until every predicted word has come out.
    task automatic wait_idle();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (yuv_words_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (yuv_words_due.size() != 0) begin
            report_mismatch("words never delivered", yuv_words_due.size(), 0);
            yuv_words_due.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Register write once the block is idle; size writes restart the frame.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH || idx == CFG_FRAME_HEIGHT) begin
            if (idx == CFG_FRAME_WIDTH) begin
                width_reg = val;
            end else begin
                height_reg = val;
            end
            col_pos = 0;
            row_pos = 0;
            pend_u  = 0;
            pend_v  = 0;
        end
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
    endtask

    // Output side: random stalls, and a long hold-off when one is requested.
    initial begin
        int hold;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req > 0) begin
                hold          = sink_hold_req;
                sink_hold_req = 0;
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat (idle_length()) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Each delivered word is checked field by field against the oldest prediction.
    always @(posedge i_clk) begin : check_words
        t_yuv_word due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (yuv_words_due.size() == 0) begin
                report_mismatch("word with none due, address", 0, o_address);
            end else begin
                due = yuv_words_due.pop_front();
                if (o_plane !== due.plane) begin
                    report_mismatch("plane", due.plane, o_plane);
                end
                if (o_address !== due.address) begin
                    report_mismatch("address", due.address, o_address);
                end
                if (o_sample !== due.sample) begin
                    report_mismatch("sample", due.sample, o_sample);
                end
                if (o_last !== due.last) begin
                    report_mismatch("last", due.last, o_last);
                end
            end
        end
    end

    // Reset sizes: black and white pixels at the default 640 by 480 frame.
    task automatic test_reset_size();
        send_pixel('0, '0, '0);
        send_pixel('1, '1, '1);
    endtask

    // Four blocks that drive U and V to both ends of their range.
    task automatic test_colour_extremes();
        logic [PIX_W-1:0] blues[4]  = '{8'hff, 8'h00, 8'h00, 8'hff};
        logic [PIX_W-1:0] greens[4] = '{8'h00, 8'hff, 8'h00, 8'hff};
        logic [PIX_W-1:0] reds[4]   = '{8'h00, 8'hff, 8'hff, 8'h00};
        int               blk;
        set_frame(13'd4, 13'd4);
        for (int y = 0; y < 4; y++) begin
            for (int x = 0; x < 4; x++) begin
                blk = (y / 2) * 2 + x / 2;
                send_pixel(blues[blk], greens[blk], reds[blk]);
            end
        end
    endtask

    // Odd, too small and too large register values, and the largest frames.
    task automatic test_frame_sizes();
        set_frame(13'd0, 13'd1);
        send_random_pixels(6);
        set_frame(13'd5, 13'd3);
        send_random_pixels(8);
        set_frame(13'd8191, 13'd2);
        send_random_pixels(6);
        set_frame(13'd4096, 13'd8191);
        send_random_pixels(4);
        set_frame(13'd2, 13'd4096);
        send_random_pixels(8);
    endtask

    // Spare indexes leave the position alone; size writes restart mid-frame.
    task automatic test_frame_restart();
        set_frame(13'd4, 13'd4);
        send_random_pixels(6);
        write_reg(CFG_SPARE_LO, 13'h1fff);
        send_random_pixels(10);
        send_random_pixels(5);
        write_reg(CFG_FRAME_HEIGHT, 13'd4);
        send_random_pixels(16);
        write_reg(CFG_SPARE_HI, 13'h0000);
        send_random_pixels(4);
    endtask

    // Output held off while pixels keep coming, then a full drain before more.
    task automatic test_output_hold();
        set_frame(13'd8, 13'd4);
        src_gaps      = 1'b0;
        sink_stalls   = 1'b0;
        sink_hold_req = 300;
        send_random_pixels(48);
        wait_idle();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        send_random_pixels(16);
    endtask

    // No idling on either side.
    task automatic test_back_to_back();
        set_frame(13'd6, 13'd4);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        send_random_pixels(40);
    endtask

    // Random frame sizes, mostly small, each with one or two frames of random pixels, at most 64.
    task automatic test_random_frames();
        logic [CFG_DATA_W-1:0] w_raw, h_raw;
        int                    sent, count;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            w_raw = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 8191))
                                                : CFG_DATA_W'($urandom_range(0, 17));
            h_raw = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 8191))
                                                : CFG_DATA_W'($urandom_range(0, 9));
            write_reg(CFG_FRAME_WIDTH, w_raw);
            if ($urandom_range(0, 3) != 0) begin
                write_reg(CFG_FRAME_HEIGHT, h_raw);
            end
            count = frame_extent(width_reg, MAX_WIDTH) * frame_extent(height_reg, MAX_HEIGHT);
            count = count * $urandom_range(1, 2);
            if ($urandom_range(0, 4) == 0) begin
                // A broken frame, cut short at a random point.
                count = $urandom_range(1, count);
            end
            if (count > 64) begin
                count = 64;
            end
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            send_random_pixels(count);
            sent += count;
        end
    endtask

    // Test sequence.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_size();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        test_colour_extremes();
        test_frame_sizes();
        test_frame_restart();
        test_output_hold();
        test_back_to_back();
        test_random_frames();
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS rgb32_to_yuv420_converter_top");
        end else begin
            $display("FAIL rgb32_to_yuv420_converter_top");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #(TIMEOUT_CYCLES * 12);
        $display("FAIL rgb32_to_yuv420_converter_top");
        $finish;
    end

endmodule
`default_nettype wire
